>>> rtl/mle_pkg.sv
// Shared types, constants and the Morse lookup for the Morse LED encoder.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package mle_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned LED_W   = 2;
    localparam int unsigned CODE_W  = 6;   // longest code has six elements
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // Lamp codes
    localparam logic [LED_W-1:0] LED_GREEN  = 2'd0;
    localparam logic [LED_W-1:0] LED_YELLOW = 2'd1;
    localparam logic [LED_W-1:0] LED_RED    = 2'd2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DOT_ON  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_ON = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_ON  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF     = 2'd3;

    localparam logic [TICK_W-1:0] DOT_ON_RESET  = 16'd250;
    localparam logic [TICK_W-1:0] DASH_ON_RESET = 16'd500;
    localparam logic [TICK_W-1:0] GAP_ON_RESET  = 16'd250;
    localparam logic [TICK_W-1:0] OFF_RESET     = 16'd100;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    typedef enum logic [1:0] {
        JOB_CODE,   // optional leading yellow, elements, optional trailing yellow
        JOB_RED,    // one red word gap
        JOB_BAD     // one error marker
    } job_kind_t;

    typedef struct packed {
        job_kind_t           kind;
        logic                lead;   // yellow before the first element
        logic                trail;  // yellow after the last element
        logic [LEN_W-1:0]    len;    // elements still to send
        logic [CODE_W-1:0]   pat;    // first element in the top bit, 1 = dash
    } job_t;

    typedef struct packed {
        logic [TICK_W-1:0] dot_on;
        logic [TICK_W-1:0] dash_on;
        logic [TICK_W-1:0] gap_on;
        logic [TICK_W-1:0] off;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] pat;
    } code_t;

    // Morse code of one byte; patterns read left to right, padded with zeros.
    function automatic code_t morse_lookup(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] lc;
        code_t             r;
        lc = c;
        if (c inside {[8'h41:8'h5A]}) begin
            lc = c | 8'h20;   // fold upper case onto lower case
        end
        r = '{valid: 1'b1, len: 3'd0, pat: 6'b000000};
        case (lc)
            8'h61: begin r.len = 3'd2; r.pat = 6'b010000; end // a
            8'h62: begin r.len = 3'd4; r.pat = 6'b100000; end // b
            8'h63: begin r.len = 3'd4; r.pat = 6'b101000; end // c
            8'h64: begin r.len = 3'd3; r.pat = 6'b100000; end // d
            8'h65: begin r.len = 3'd1; r.pat = 6'b000000; end // e
            8'h66: begin r.len = 3'd4; r.pat = 6'b001000; end // f
            8'h67: begin r.len = 3'd3; r.pat = 6'b110000; end // g
            8'h68: begin r.len = 3'd4; r.pat = 6'b000000; end // h
            8'h69: begin r.len = 3'd2; r.pat = 6'b000000; end // i
            8'h6A: begin r.len = 3'd4; r.pat = 6'b011100; end // j
            8'h6B: begin r.len = 3'd3; r.pat = 6'b101000; end // k
            8'h6C: begin r.len = 3'd4; r.pat = 6'b010000; end // l
            8'h6D: begin r.len = 3'd2; r.pat = 6'b110000; end // m
            8'h6E: begin r.len = 3'd2; r.pat = 6'b100000; end // n
            8'h6F: begin r.len = 3'd3; r.pat = 6'b111000; end // o
            8'h70: begin r.len = 3'd4; r.pat = 6'b011000; end // p
            8'h71: begin r.len = 3'd4; r.pat = 6'b110100; end // q
            8'h72: begin r.len = 3'd3; r.pat = 6'b010000; end // r
            8'h73: begin r.len = 3'd3; r.pat = 6'b000000; end // s
            8'h74: begin r.len = 3'd1; r.pat = 6'b100000; end // t
            8'h75: begin r.len = 3'd3; r.pat = 6'b001000; end // u
            8'h76: begin r.len = 3'd4; r.pat = 6'b000100; end // v
            8'h77: begin r.len = 3'd3; r.pat = 6'b011000; end // w
            8'h78: begin r.len = 3'd4; r.pat = 6'b100100; end // x
            8'h79: begin r.len = 3'd4; r.pat = 6'b101100; end // y
            8'h7A: begin r.len = 3'd4; r.pat = 6'b110000; end // z
            8'h2E: begin r.len = 3'd6; r.pat = 6'b010101; end // full stop
            8'h2C: begin r.len = 3'd6; r.pat = 6'b110011; end // comma
            8'h3F: begin r.len = 3'd6; r.pat = 6'b001100; end // question mark
            8'h21: begin r.len = 3'd6; r.pat = 6'b101011; end // exclamation mark
            8'h27: begin r.len = 3'd6; r.pat = 6'b011110; end // apostrophe
            default: r.valid = 1'b0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/mle_front.sv
// Front end: takes characters, tracks the pending gap and discard state,
// and turns each character into at most one pulse job. Uses mle_pkg.
module mle_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mle_pkg::CHAR_W-1:0]   in_char,
    input  logic                         in_eom,
    input  logic                         q_full,
    output logic                         push,
    output mle_pkg::job_t                push_job
);

    logic           gap_pending_reg, gap_pending_next;
    logic           discarding_reg, discarding_next;
    logic           accept;
    mle_pkg::code_t code;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign code     = mle_pkg::morse_lookup(in_char);

    always_comb begin
        gap_pending_next = gap_pending_reg;
        discarding_next  = discarding_reg;
        push             = 1'b0;
        push_job         = '{kind: mle_pkg::JOB_CODE, lead: 1'b0, trail: 1'b0,
                             len: '0, pat: '0};
        if (accept) begin
            if (discarding_reg) begin
                // drop until the end of the message
                if (in_eom) begin
                    discarding_next = 1'b0;
                end
            end else if (in_char == mle_pkg::CHAR_SPACE) begin
                if (gap_pending_reg) begin
                    push             = 1'b1;
                    push_job.kind    = mle_pkg::JOB_RED;
                    gap_pending_next = 1'b0;
                end else if (in_eom) begin
                    push             = 1'b1;
                    push_job.trail   = 1'b1;
                    gap_pending_next = 1'b0;
                end else begin
                    gap_pending_next = 1'b1;
                end
            end else if (code.valid) begin
                push             = 1'b1;
                push_job.lead    = gap_pending_reg;
                push_job.trail   = in_eom;
                push_job.len     = code.len;
                push_job.pat     = code.pat;
                gap_pending_next = !in_eom;
            end else begin
                push             = 1'b1;
                push_job.kind    = mle_pkg::JOB_BAD;
                gap_pending_next = 1'b0;
                discarding_next  = !in_eom;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_pending_reg <= 1'b0;
            discarding_reg  <= 1'b0;
        end else begin
            gap_pending_reg <= gap_pending_next;
            discarding_reg  <= discarding_next;
        end
    end

endmodule

>>> rtl/mle_queue.sv
// Short job queue between the front end and the pulse sequencer.
// Register based, first in first out. Uses mle_pkg for the job type.
module mle_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mle_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output mle_pkg::job_t q_job
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    mle_pkg::job_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign q_job   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/mle_back.sv
// Pulse sequencer: steps through one job per character and sends one pulse a
// cycle to the output register unless stalled. Uses mle_pkg for job, config types.
module mle_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mle_pkg::cfg_t               cfg,
    input  logic                        q_valid,
    input  mle_pkg::job_t               q_job,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [mle_pkg::LED_W-1:0]   out_led,
    output logic [mle_pkg::TICK_W-1:0]  out_on,
    output logic [mle_pkg::TICK_W-1:0]  out_dark,
    output logic                        out_bad,
    output logic                        out_last
);

    mle_pkg::job_t               job_reg, job_next, job_adv;
    logic                        busy_reg, busy_next;
    logic                        valid_reg, valid_next;
    logic [mle_pkg::LED_W-1:0]   led_reg, p_led;
    logic [mle_pkg::TICK_W-1:0]  on_reg, p_on;
    logic [mle_pkg::TICK_W-1:0]  dark_reg, p_dark;
    logic                        bad_reg, p_bad;
    logic                        last_reg, p_last;
    logic                        can_load, fire;

    // Work out the pulse at the head of the current job and the job left after it
    always_comb begin
        job_adv = job_reg;
        p_led   = mle_pkg::LED_GREEN;
        p_on    = '0;
        p_dark  = cfg.off;
        p_bad   = 1'b0;
        p_last  = 1'b1;
        case (job_reg.kind)
            mle_pkg::JOB_CODE: begin
                if (job_reg.lead) begin
                    p_led        = mle_pkg::LED_YELLOW;
                    p_on         = cfg.gap_on;
                    p_last       = (job_reg.len == '0) && !job_reg.trail;
                    job_adv.lead = 1'b0;
                end else if (job_reg.len != '0) begin
                    p_led       = mle_pkg::LED_GREEN;
                    p_on        = job_reg.pat[mle_pkg::CODE_W-1] ? cfg.dash_on : cfg.dot_on;
                    p_last      = (job_reg.len == 3'd1) && !job_reg.trail;
                    job_adv.len = job_reg.len - 1'b1;
                    job_adv.pat = {job_reg.pat[mle_pkg::CODE_W-2:0], 1'b0};
                end else begin
                    p_led         = mle_pkg::LED_YELLOW;
                    p_on          = cfg.gap_on;
                    job_adv.trail = 1'b0;
                end
            end
            mle_pkg::JOB_RED: begin
                p_led = mle_pkg::LED_RED;
                p_on  = cfg.gap_on;
            end
            mle_pkg::JOB_BAD: begin
                p_dark = '0;
                p_bad  = 1'b1;
            end
            default: begin
                p_dark = '0;
                p_bad  = 1'b1;
            end
        endcase
    end

    always_comb begin
        can_load   = !valid_reg || out_ready;
        fire       = busy_reg && can_load;
        pop        = q_valid && (!busy_reg || (fire && p_last));
        valid_next = fire ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
        if (pop) begin
            busy_next = 1'b1;
            job_next  = q_job;
        end else if (fire) begin
            busy_next = !p_last;
            job_next  = job_adv;
        end else begin
            busy_next = busy_reg;
            job_next  = job_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        if (fire) begin
            led_reg  <= p_led;
            on_reg   <= p_on;
            dark_reg <= p_dark;
            bad_reg  <= p_bad;
            last_reg <= p_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_led   = led_reg;
    assign out_on    = on_reg;
    assign out_dark  = dark_reg;
    assign out_bad   = bad_reg;
    assign out_last  = last_reg;

endmodule

>>> rtl/morse_led_encoder.sv
// Top level of the Morse LED encoder: configuration registers, front end,
// job queue and pulse sequencer. Depends on mle_pkg, mle_front, mle_queue, mle_back.
//
// Usage
//   Send one ASCII character per request on the s_ channel, with s_tlast
//   high on the final character of a message. Each character yields zero to
//   eight lamp pulses on the m_ channel; m_tlast marks the last pulse that
//   a character caused, and m_tuser flags an unsupported character (that
//   request carries no pulse, and the rest of its message is dropped).
//   Timing registers are written through cfg_wr_en / cfg_index / cfg_wdata
//   while the block is idle; they take effect on the next pulse.
// Path and throughput
//   A character is written into the job queue, then loaded into the
//   sequencer's job register, and its first pulse then goes to the output
//   register. The sequencer sends one pulse per cycle unless m_tready
//   stalls it. The front end takes a character every cycle while the job
//   queue (QUEUE_DEPTH entries) has room.
// Reset and stalls
//   Reset clears the pending gap, the discard state, the queue and the
//   output valid flag, and loads the default timings (250, 500, 250, 100).
//   When m_tready is low the current pulse is held in the output register,
//   the sequencer waits, the queue fills and then s_tready falls.
module morse_led_encoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_message
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [1:0] led, [17:2] on_ticks, [33:18] dark_ticks, zero above
    output logic [0:0]  m_tuser,   // [0] bad_char
    output logic        m_tlast,   // run_end
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    mle_pkg::cfg_t                cfg_reg;
    logic                         q_full, push, pop, q_valid;
    mle_pkg::job_t                push_job, q_job;
    logic [mle_pkg::LED_W-1:0]    led;
    logic [mle_pkg::TICK_W-1:0]   on_ticks, dark_ticks;
    logic                         bad_char;

    // Timing registers; an index selects one, and a write is registered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dot_on  <= mle_pkg::DOT_ON_RESET;
            cfg_reg.dash_on <= mle_pkg::DASH_ON_RESET;
            cfg_reg.gap_on  <= mle_pkg::GAP_ON_RESET;
            cfg_reg.off     <= mle_pkg::OFF_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mle_pkg::REG_DOT_ON:  cfg_reg.dot_on  <= cfg_wdata;
                mle_pkg::REG_DASH_ON: cfg_reg.dash_on <= cfg_wdata;
                mle_pkg::REG_GAP_ON:  cfg_reg.gap_on  <= cfg_wdata;
                mle_pkg::REG_OFF:     cfg_reg.off     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Classify characters and keep the gap pairing state
    mle_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_char  (s_tdata),
        .in_eom   (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    // Decouple the front end from the sequencer
    mle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    // Expand each job into pulses
    mle_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_led   (led),
        .out_on    (on_ticks),
        .out_dark  (dark_ticks),
        .out_bad   (bad_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {6'd0, dark_ticks, on_ticks, led};
    assign m_tuser = bad_char;

endmodule

>>> rtl/mle_checker.sv
// Port-level checks for the Morse LED encoder, bound to the top level.
// Depends on mle_pkg and morse_led_encoder.
module mle_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // Hold the data and last flag of a stalled pulse unchanged
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled pulse changed");

    // An error marker carries no pulse and closes its request
    a_bad_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == 40'd0))
        else $error("error marker not alone or not empty");

    // A red word gap always closes its request and is not flagged bad
    a_red_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == mle_pkg::LED_RED) |-> m_tlast && !m_tuser[0])
        else $error("red gap not closing its request");

    // Drop the output during reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind morse_led_encoder mle_checker u_mle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
